// ===== hdl/bpq_pkg.sv =====
package bpq_pkg;
    localparam int DEF_CAPACITY = 16;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int OCC_W = 5;
    localparam int ENTRY_W = KEY_W + VAL_W;

    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        status;
        logic [KEY_W-1:0]  top_priority;
        logic [VAL_W-1:0]  top_value;
    } t_result;
endpackage

// ===== hdl/bpq_ram.sv =====
module bpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/bpq_ctrl.sv =====
module bpq_ctrl
    import bpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_order,
    input  logic                        i_start,
    input  logic [1:0]                  i_mode,
    input  logic [KEY_W-1:0]            i_prio,
    input  logic [VAL_W-1:0]            i_val,
    output logic                        o_busy,
    output logic                        o_done,
    output t_result                     o_res,
    output logic [$clog2(CAPACITY+1)-1:0] o_count,
    output logic                        o_we,
    output logic [$clog2(CAPACITY)-1:0] o_waddr,
    output logic [ENTRY_W-1:0]          o_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_raddr,
    input  logic [ENTRY_W-1:0]          i_rdata
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT} t_state;

    t_state           r_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_idx;
    logic [AW-1:0]    r_best;
    logic [ENTRY_W-1:0] r_best_e;
    logic             r_pop;
    logic             r_rvalid;
    logic [CW-1:0]    r_ridx;
    logic [CW-1:0]    n_idx;
    logic             w_before;
    logic signed [KEY_W-1:0] w_rk, w_bk;

    assign w_rk = i_rdata[ENTRY_W-1 -: KEY_W];
    assign w_bk = r_best_e[ENTRY_W-1 -: KEY_W];
    assign w_before = (r_ridx == '0) ||
                      (i_order ? (w_rk > w_bk) : (w_rk < w_bk));
    assign o_busy = (r_state != S_IDLE);
    assign o_count = r_count;
    assign n_idx = r_idx + CW'(1);

    always_comb begin
        o_raddr = r_idx[AW-1:0];
        o_we = 1'b0;
        o_waddr = r_count[AW-1:0];
        o_wdata = {i_prio, i_val};
        if (r_state == S_IDLE) begin
            o_raddr = '0;
            o_we = i_start && (i_mode == MODE_PUSH) && (r_count < CW'(CAPACITY));
        end else if (r_state == S_SCAN && !r_rvalid) begin
            o_raddr = r_best + AW'(1);
        end else if (r_state == S_SHIFT && r_rvalid) begin
            o_we = 1'b1;
            o_waddr = AW'(r_ridx - CW'(1));
            o_wdata = i_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_done <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        o_res <= '{ST_OK, '0, '0};
                        r_pop <= (i_mode == MODE_POP);
                        r_idx <= CW'(1);
                        r_ridx <= '0;
                        case (i_mode)
                            MODE_PUSH: begin
                                o_done <= 1'b1;
                                if (r_count < CW'(CAPACITY)) begin
                                    r_count <= r_count + CW'(1);
                                end else begin
                                    o_res.status <= ST_FULL;
                                end
                            end
                            MODE_POP, MODE_PEEK: begin
                                if (r_count == '0) begin
                                    o_res.status <= ST_EMPTY;
                                    o_done <= 1'b1;
                                end else begin
                                    r_state <= S_SCAN;
                                    r_rvalid <= 1'b1;
                                end
                            end
                            default: o_done <= 1'b1;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_rvalid && w_before) begin
                        r_best <= AW'(r_ridx);
                        r_best_e <= i_rdata;
                    end
                    r_ridx <= r_idx;
                    r_rvalid <= (r_idx < r_count);
                    r_idx <= n_idx;
                    if (!r_rvalid) begin
                        o_res.top_priority <= r_best_e[ENTRY_W-1 -: KEY_W];
                        o_res.top_value <= r_best_e[VAL_W-1:0];
                        if (r_pop) begin
                            r_state <= S_SHIFT;
                            r_idx <= CW'(r_best) + CW'(2);
                            r_ridx <= CW'(r_best) + CW'(1);
                            r_rvalid <= (CW'(r_best) + CW'(1)) < r_count;
                        end else begin
                            r_state <= S_IDLE;
                            o_done <= 1'b1;
                        end
                    end
                end
                S_SHIFT: begin
                    r_ridx <= r_idx;
                    r_rvalid <= (r_idx < r_count);
                    r_idx <= n_idx;
                    if (!r_rvalid) begin
                        r_state <= S_IDLE;
                        r_count <= r_count - CW'(1);
                        o_done <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/bounded_priority_queue.sv =====
// Channel  Direction  tdata (low bit up)                          tuser
// s_axis   in         mode[1:0], priority_req[33:2], value[65:34] -
// m_axis   out        status[1:0], top_priority[33:2],            -
//                     top_value[65:34], occupancy[70:66]
// cfg      in         order_select on i_cfg_wdata[0]
// A push, or any request that ends at once, completes without a scan; a pop or
// peek reads each held entry through the single RAM read port, and a pop then
// shifts the entries after the top one down to close the gap. Reset clears the
// count, the order select and the output valid flag, not the RAM.
// One request at a time; a waiting result holds the next request back.
module bounded_priority_queue
    import bpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // mode, priority_req, value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // status, top_priority, top_value, occupancy
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic r_order;
    logic r_ovalid;
    logic w_busy, w_done, w_start, w_we;
    t_result w_res;
    logic [CW-1:0] w_count;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [ENTRY_W-1:0] w_wdata, w_rdata;

    assign s_axis_tready = !w_busy && !r_ovalid && !w_done;
    assign w_start = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
            if (w_done) begin
                r_ovalid <= 1'b1;
                m_axis_tdata <= {1'b0, OCC_W'(w_count), w_res.top_value,
                                 w_res.top_priority, w_res.status};
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    bpq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_order(r_order),
        .i_start(w_start), .i_mode(s_axis_tdata[1:0]),
        .i_prio(s_axis_tdata[33:2]), .i_val(s_axis_tdata[65:34]),
        .o_busy(w_busy), .o_done(w_done), .o_res(w_res), .o_count(w_count),
        .o_we(w_we), .o_waddr(w_waddr), .o_wdata(w_wdata),
        .o_raddr(w_raddr), .i_rdata(w_rdata)
    );

    bpq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

`ifndef NO_ASSERTIONS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(CAPACITY)) else $error("count above capacity");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !s_axis_tready) else $error("second request taken");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !r_ovalid) else $error("result overwritten");
`endif
endmodule
